// ===== src/bsk_pkg.sv =====
// ----------------------------------------------------------------------------
// B-spline knot insertion package
// Store sizes, request and status codes, sequencer states and unit status.
// ----------------------------------------------------------------------------
package bsk_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_COORDS = 4;
  localparam int MAX_KNOTS  = 72;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int KA_W   = $clog2(MAX_KNOTS);
  localparam int PA_W   = $clog2(MAX_POINTS * MAX_COORDS);
  localparam int CO_W   = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;

  localparam logic [2:0] REQ_WR_KNOT  = 3'd0;
  localparam logic [2:0] REQ_WR_POINT = 3'd1;
  localparam logic [2:0] REQ_INSERT   = 3'd2;
  localparam logic [2:0] REQ_RD_KNOT  = 3'd3;
  localparam logic [2:0] REQ_RD_POINT = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_COORDS = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_RD_KNOT,
    S_RD_POINT,
    S_SPAN_TOP,
    S_SPAN_TOP_CMP,
    S_SPAN_RD,
    S_SPAN_CMP,
    S_MULT_RD,
    S_MULT_CMP,
    S_CLAMP,
    S_SH_RD,
    S_SH_WR,
    S_BL_K0,
    S_BL_K1,
    S_BL_K2,
    S_BL_DIV,
    S_BL_P0,
    S_BL_P1,
    S_BL_P2,
    S_BL_MUL,
    S_SP_RD,
    S_SP_WR,
    S_SP_LAST,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== src/bsk_div.sv =====
// ----------------------------------------------------------------------------
// Blend factor divider
// Bit-serial restoring division of (num * 65536) by den, one quotient bit per
// cycle, truncated toward zero and saturated to Q16.16; zero when den is zero.
// ----------------------------------------------------------------------------
module bsk_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [32:0]        num,
  input  logic signed [32:0]        den,
  output logic signed [31:0]        alpha,
  output bsk_pkg::unit_stat_t       stat
);

  localparam int NW  = 33 + 16;
  localparam int CW  = $clog2(NW + 1);

  logic [NW-1:0] dq;
  logic [33:0]   rem;
  logic [32:0]   dv;
  logic          neg;
  logic          dz;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [32:0]   mag_n;
  logic [32:0]   mag_d;
  logic [33:0]   rem_sh;
  logic [34:0]   trial;
  logic          ge;

  assign mag_n  = num[32] ? 33'(33'd0 - num) : num;
  assign mag_d  = den[32] ? 33'(33'd0 - den) : den;
  assign rem_sh = {rem[32:0], dq[NW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dv};
  assign ge     = !trial[34];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= {mag_n, 16'd0};
      rem <= '0;
      dv  <= mag_d;
      neg <= num[32] ^ den[32];
      dz  <= (den == 33'sd0);
    end else if (busy) begin
      dq  <= {dq[NW-2:0], ge};
      rem <= ge ? trial[33:0] : rem_sh;
    end
  end

  always_comb begin
    if (dz) begin
      alpha = 32'sd0;
    end else if (neg) begin
      alpha = (dq > NW'(33'h0_8000_0000)) ? 32'sh8000_0000 : 32'(32'd0 - dq[31:0]);
    end else begin
      alpha = (dq > NW'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF : dq[31:0];
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

// ===== src/bsk_mul.sv =====
// ----------------------------------------------------------------------------
// Point blend multiplier
// Shift-add multiply of (cur - prev) by alpha, one bit per cycle, then
// prev + floor(product / 65536) saturated to 32 bits.
// ----------------------------------------------------------------------------
module bsk_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [31:0]        prev,
  input  logic signed [31:0]        cur,
  input  logic signed [31:0]        alpha,
  output logic signed [31:0]        result,
  output bsk_pkg::unit_stat_t       stat
);

  logic [33:0]        hi;
  logic [31:0]        lo;
  logic [32:0]        md;
  logic               neg;
  logic signed [31:0] prev_r;
  logic [4:0]         cnt;
  logic               busy;
  logic               done;

  logic signed [32:0] diff;
  logic [33:0]        sum;
  logic [66:0]        mag;
  logic signed [66:0] sprod;
  logic signed [50:0] t;
  logic signed [51:0] acc;

  assign diff = $signed({cur[31], cur}) - $signed({prev[31], prev});
  assign sum  = hi + {1'b0, (lo[0] ? md : 33'd0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi     <= '0;
      lo     <= alpha[31] ? 32'(32'd0 - alpha) : alpha;
      md     <= diff[32] ? 33'(33'd0 - diff) : diff;
      neg    <= diff[32] ^ alpha[31];
      prev_r <= prev;
    end else if (busy) begin
      hi <= {1'b0, sum[33:1]};
      lo <= {sum[0], lo[31:1]};
    end
  end

  assign mag   = {1'b0, hi, lo};
  assign sprod = neg ? $signed(67'(67'd0 - mag)) : $signed(mag);
  assign t     = sprod[66:16];
  assign acc   = $signed({{20{prev_r[31]}}, prev_r}) + $signed({t[50], t});

  always_comb begin
    if (acc > 52'sd2147483647) begin
      result = 32'sh7FFF_FFFF;
    end else if (acc < -52'sd2147483648) begin
      result = 32'sh8000_0000;
    end else begin
      result = acc[31:0];
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

// ===== src/bspline_curve_knot_insert_top.sv =====
// ----------------------------------------------------------------------------
// B-spline curve knot insertion
// Knot vector and control point stores in Q16.16 with Boehm insertion.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives one result transaction. An
// insertion is run by a sequencer around two single-read-port memories
// (knots and point coordinates): a span search and a multiplicity scan first
// fix the repetition count; then each repetition runs a span search, a shift
// of the stored coordinate words above the span (MAX_COORDS words per point),
// a blend of each of the degree points through the serial divider and, per
// coordinate, the serial multiplier, and a knot splice. A new request is
// taken while the last result waits at the output. The stores have no reset
// and need no clearing pass.
module bspline_curve_knot_insert_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,   // 0 degree, 1 coord_count
  input  logic [2:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,     // slot[6:0], axis[8:7], value[40:9], repeats[43:41]
  input  logic [2:0]  s_tuser,     // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata      // read_value[31:0], done_count[34:32], status[36:35],
                                   // points_now[43:37], knots_now[50:44]
);

  localparam int KA_W = bsk_pkg::KA_W;
  localparam int PA_W = bsk_pkg::PA_W;
  localparam int CO_W = bsk_pkg::CO_W;
  localparam int CW   = bsk_pkg::CNT_W;
  localparam logic [CO_W-1:0] CC_LAST = CO_W'(bsk_pkg::MAX_COORDS - 1);

  bsk_pkg::state_t state, state_next;

  logic [2:0]         req_r;
  logic [6:0]         slot_r;
  logic [1:0]         axis_r;
  logic signed [31:0] val_r;
  logic [2:0]         reps_r;

  logic [2:0]         degree;
  logic [2:0]         coord_count;
  logic [CW-1:0]      pt;
  logic [CW-1:0]      kt;

  logic [KA_W-1:0]    k_idx;
  logic [KA_W-1:0]    idx;
  logic [KA_W-1:0]    s_cnt;
  logic [2:0]         rep;
  logic [CO_W-1:0]    cc;
  logic               first;
  logic signed [31:0] knot_a;
  logic signed [31:0] prev_p;
  logic [31:0]        rd;
  logic [2:0]         done_r;
  logic [1:0]         status_r;

  logic signed [31:0] kmem [bsk_pkg::MAX_KNOTS];
  logic signed [31:0] pmem [bsk_pkg::MAX_POINTS * bsk_pkg::MAX_COORDS];
  logic [KA_W-1:0]    k_raddr, k_waddr;
  logic               k_we;
  logic signed [31:0] k_wdata, k_rdata;
  logic [PA_W-1:0]    p_raddr, p_waddr;
  logic               p_we;
  logic signed [31:0] p_wdata, p_rdata;

  logic               div_start, mul_start;
  logic signed [31:0] alpha, mul_res;
  bsk_pkg::unit_stat_t div_stat, mul_stat;
  logic signed [32:0] num, den;

  logic [2:0]         cu;
  logic               wk_ok, wp_ok, rk_ok, rp_ok;
  logic               consistent, ins_go;
  logic [1:0]         ins_status;
  logic [KA_W-1:0]    n_idx, p_k, lo_i, k_fin;
  logic               span_end;
  logic [KA_W:0]      sr;
  logic [2:0]         r_eff;
  logic               ovf;
  logic               out_free;

  function automatic logic [PA_W-1:0] paddr(input logic [KA_W-1:0] i,
                                            input logic [CO_W-1:0] c);
    paddr = PA_W'(PA_W'(i) * PA_W'(bsk_pkg::MAX_COORDS) + PA_W'(c));
  endfunction

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == bsk_pkg::S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  assign cu    = (coord_count > 3'(bsk_pkg::MAX_COORDS)) ? 3'(bsk_pkg::MAX_COORDS)
                                                         : coord_count;
  assign wk_ok = int'(slot_r) < bsk_pkg::MAX_KNOTS;
  assign wp_ok = (int'(slot_r) < bsk_pkg::MAX_POINTS) && ({1'b0, axis_r} < cu);
  assign rk_ok = slot_r < kt;
  assign rp_ok = (slot_r < pt) && ({1'b0, axis_r} < cu);

  assign consistent = (int'(kt) == int'(pt) + int'(degree) + 1) &&
                      (int'(pt) >= int'(degree) + 1);
  assign ins_go = (reps_r != 3'd0) && (kt != '0) && (pt != '0) && (degree != 3'd0) &&
                  consistent;

  always_comb begin
    if (reps_r == 3'd0) begin
      ins_status = bsk_pkg::ST_OK;
    end else if (kt == '0 || pt == '0) begin
      ins_status = bsk_pkg::ST_EMPTY;
    end else if (degree == 3'd0) begin
      ins_status = bsk_pkg::ST_OK;
    end else if (!consistent) begin
      ins_status = bsk_pkg::ST_RANGE;
    end else begin
      ins_status = bsk_pkg::ST_OK;
    end
  end

  assign n_idx = KA_W'(pt) - 1'b1;
  assign p_k   = KA_W'(degree);
  assign lo_i  = k_idx - p_k + 1'b1;
  assign k_fin = (state == bsk_pkg::S_SPAN_TOP_CMP) ? n_idx : k_idx;

  assign span_end = ((state == bsk_pkg::S_SPAN_TOP_CMP) && (val_r >= k_rdata)) ||
                    ((state == bsk_pkg::S_SPAN_CMP) &&
                     !((k_idx > p_k) && (k_rdata > val_r)));

  always_comb begin
    sr = (KA_W+1)'(s_cnt) + (KA_W+1)'(reps_r);
    if (sr > (KA_W+1)'(degree)) begin
      r_eff = (s_cnt >= p_k) ? 3'd0 : 3'(p_k - s_cnt);
    end else begin
      r_eff = reps_r;
    end
  end

  assign ovf = (int'(pt) + int'(r_eff) > bsk_pkg::MAX_POINTS) ||
               (int'(kt) + int'(r_eff) > bsk_pkg::MAX_KNOTS);

  assign num = $signed({val_r[31], val_r}) - $signed({knot_a[31], knot_a});
  assign den = $signed({k_rdata[31], k_rdata}) - $signed({knot_a[31], knot_a});

  always_ff @(posedge clk) begin
    if (k_we) begin
      kmem[k_waddr] <= k_wdata;
    end
    k_rdata <= kmem[k_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    p_rdata <= pmem[p_raddr];
  end

  bsk_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .alpha (alpha),
    .stat  (div_stat)
  );

  bsk_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .prev   (prev_p),
    .cur    (p_rdata),
    .alpha  (alpha),
    .result (mul_res),
    .stat   (mul_stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      bsk_pkg::S_IDLE: begin
        if (s_tvalid) state_next = bsk_pkg::S_DECODE;
      end
      bsk_pkg::S_DECODE: begin
        case (req_r)
          bsk_pkg::REQ_RD_KNOT:  state_next = rk_ok ? bsk_pkg::S_RD_KNOT : bsk_pkg::S_FINISH;
          bsk_pkg::REQ_RD_POINT: state_next = rp_ok ? bsk_pkg::S_RD_POINT : bsk_pkg::S_FINISH;
          bsk_pkg::REQ_INSERT:   state_next = ins_go ? bsk_pkg::S_SPAN_TOP : bsk_pkg::S_FINISH;
          default:               state_next = bsk_pkg::S_FINISH;
        endcase
      end
      bsk_pkg::S_RD_KNOT:      state_next = bsk_pkg::S_FINISH;
      bsk_pkg::S_RD_POINT:     state_next = bsk_pkg::S_FINISH;
      bsk_pkg::S_SPAN_TOP:     state_next = bsk_pkg::S_SPAN_TOP_CMP;
      bsk_pkg::S_SPAN_TOP_CMP,
      bsk_pkg::S_SPAN_CMP: begin
        if (span_end) begin
          state_next = first ? bsk_pkg::S_MULT_RD : bsk_pkg::S_SH_RD;
        end else begin
          state_next = bsk_pkg::S_SPAN_RD;
        end
      end
      bsk_pkg::S_SPAN_RD:      state_next = bsk_pkg::S_SPAN_CMP;
      bsk_pkg::S_MULT_RD: begin
        state_next = (idx == '0) ? bsk_pkg::S_CLAMP : bsk_pkg::S_MULT_CMP;
      end
      bsk_pkg::S_MULT_CMP: begin
        state_next = (k_rdata == val_r) ? bsk_pkg::S_MULT_RD : bsk_pkg::S_CLAMP;
      end
      bsk_pkg::S_CLAMP: begin
        state_next = (ovf || r_eff == 3'd0) ? bsk_pkg::S_FINISH : bsk_pkg::S_SPAN_TOP;
      end
      bsk_pkg::S_SH_RD: begin
        state_next = (idx <= k_idx) ? bsk_pkg::S_BL_K0 : bsk_pkg::S_SH_WR;
      end
      bsk_pkg::S_SH_WR:        state_next = bsk_pkg::S_SH_RD;
      bsk_pkg::S_BL_K0:        state_next = bsk_pkg::S_BL_K1;
      bsk_pkg::S_BL_K1:        state_next = bsk_pkg::S_BL_K2;
      bsk_pkg::S_BL_K2:        state_next = bsk_pkg::S_BL_DIV;
      bsk_pkg::S_BL_DIV: begin
        if (div_stat.done) state_next = bsk_pkg::S_BL_P0;
      end
      bsk_pkg::S_BL_P0:        state_next = bsk_pkg::S_BL_P1;
      bsk_pkg::S_BL_P1:        state_next = bsk_pkg::S_BL_P2;
      bsk_pkg::S_BL_P2:        state_next = bsk_pkg::S_BL_MUL;
      bsk_pkg::S_BL_MUL: begin
        if (mul_stat.done) begin
          if (cc != CC_LAST) begin
            state_next = bsk_pkg::S_BL_P0;
          end else if (idx == lo_i) begin
            state_next = bsk_pkg::S_SP_RD;
          end else begin
            state_next = bsk_pkg::S_BL_K0;
          end
        end
      end
      bsk_pkg::S_SP_RD: begin
        state_next = (idx <= k_idx + 1'b1) ? bsk_pkg::S_SP_LAST : bsk_pkg::S_SP_WR;
      end
      bsk_pkg::S_SP_WR:        state_next = bsk_pkg::S_SP_RD;
      bsk_pkg::S_SP_LAST: begin
        state_next = (rep == 3'd1) ? bsk_pkg::S_FINISH : bsk_pkg::S_SPAN_TOP;
      end
      bsk_pkg::S_FINISH: begin
        if (out_free) state_next = bsk_pkg::S_IDLE;
      end
      default:                 state_next = bsk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    k_raddr   = '0;
    k_we      = 1'b0;
    k_waddr   = '0;
    k_wdata   = '0;
    p_raddr   = '0;
    p_we      = 1'b0;
    p_waddr   = '0;
    p_wdata   = '0;
    div_start = 1'b0;
    mul_start = 1'b0;
    case (state)
      bsk_pkg::S_DECODE: begin
        k_raddr = KA_W'(slot_r);
        p_raddr = paddr(KA_W'(slot_r), CO_W'(axis_r));
        k_we    = (req_r == bsk_pkg::REQ_WR_KNOT) && wk_ok;
        k_waddr = KA_W'(slot_r);
        k_wdata = val_r;
        p_we    = (req_r == bsk_pkg::REQ_WR_POINT) && wp_ok;
        p_waddr = paddr(KA_W'(slot_r), CO_W'(axis_r));
        p_wdata = val_r;
      end
      bsk_pkg::S_SPAN_TOP: k_raddr = KA_W'(pt);
      bsk_pkg::S_SPAN_RD:  k_raddr = k_idx;
      bsk_pkg::S_MULT_RD:  k_raddr = idx - 1'b1;
      bsk_pkg::S_SH_RD:    p_raddr = paddr(idx - 1'b1, cc);
      bsk_pkg::S_SH_WR: begin
        p_we    = 1'b1;
        p_waddr = paddr(idx, cc);
        p_wdata = p_rdata;
      end
      bsk_pkg::S_BL_K0:    k_raddr = idx;
      bsk_pkg::S_BL_K1:    k_raddr = idx + p_k;
      bsk_pkg::S_BL_K2:    div_start = 1'b1;
      bsk_pkg::S_BL_P0:    p_raddr = paddr(idx - 1'b1, cc);
      bsk_pkg::S_BL_P1:    p_raddr = paddr(idx, cc);
      bsk_pkg::S_BL_P2:    mul_start = 1'b1;
      bsk_pkg::S_BL_MUL: begin
        p_we    = mul_stat.done;
        p_waddr = paddr(idx, cc);
        p_wdata = mul_res;
      end
      bsk_pkg::S_SP_RD:    k_raddr = idx - 1'b1;
      bsk_pkg::S_SP_WR: begin
        k_we    = 1'b1;
        k_waddr = idx;
        k_wdata = k_rdata;
      end
      bsk_pkg::S_SP_LAST: begin
        k_we    = 1'b1;
        k_waddr = k_idx + 1'b1;
        k_wdata = val_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      degree      <= 3'd3;
      coord_count <= 3'd3;
    end else if (cfg_valid) begin
      if (cfg_index == bsk_pkg::CFG_DEGREE) begin
        degree <= cfg_data;
      end else begin
        coord_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bsk_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == bsk_pkg::S_FINISH && out_free) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bsk_pkg::S_FINISH && out_free) begin
      m_tdata <= {5'd0, kt, pt, status_r, done_r, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt <= '0;
      kt <= '0;
    end else begin
      case (state)
        bsk_pkg::S_DECODE: begin
          if (req_r == bsk_pkg::REQ_WR_KNOT && wk_ok) kt <= CW'(slot_r) + 1'b1;
          if (req_r == bsk_pkg::REQ_WR_POINT && wp_ok) pt <= CW'(slot_r) + 1'b1;
        end
        bsk_pkg::S_SP_LAST: begin
          pt <= pt + 1'b1;
          kt <= kt + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bsk_pkg::S_IDLE: begin
        if (s_tvalid) begin
          req_r    <= s_tuser;
          slot_r   <= s_tdata[6:0];
          axis_r   <= s_tdata[8:7];
          val_r    <= s_tdata[40:9];
          reps_r   <= s_tdata[43:41];
          rd       <= '0;
          done_r   <= '0;
          status_r <= bsk_pkg::ST_OK;
          first    <= 1'b1;
        end
      end
      bsk_pkg::S_DECODE: begin
        case (req_r)
          bsk_pkg::REQ_WR_KNOT:  if (!wk_ok) status_r <= bsk_pkg::ST_RANGE;
          bsk_pkg::REQ_WR_POINT: if (!wp_ok) status_r <= bsk_pkg::ST_RANGE;
          bsk_pkg::REQ_RD_KNOT:  if (!rk_ok) status_r <= bsk_pkg::ST_RANGE;
          bsk_pkg::REQ_RD_POINT: if (!rp_ok) status_r <= bsk_pkg::ST_RANGE;
          bsk_pkg::REQ_INSERT:   status_r <= ins_status;
          default: begin
          end
        endcase
      end
      bsk_pkg::S_RD_KNOT:  rd <= k_rdata;
      bsk_pkg::S_RD_POINT: rd <= p_rdata;
      bsk_pkg::S_SPAN_TOP_CMP,
      bsk_pkg::S_SPAN_CMP: begin
        if (state == bsk_pkg::S_SPAN_TOP_CMP) begin
          k_idx <= n_idx;
        end else if (!span_end) begin
          k_idx <= k_idx - 1'b1;
        end
        if (span_end) begin
          idx   <= first ? k_fin + 1'b1 : KA_W'(pt);
          s_cnt <= '0;
          cc    <= '0;
        end
      end
      bsk_pkg::S_MULT_CMP: begin
        if (k_rdata == val_r) begin
          s_cnt <= s_cnt + 1'b1;
          idx   <= idx - 1'b1;
        end
      end
      bsk_pkg::S_CLAMP: begin
        if (ovf) begin
          status_r <= bsk_pkg::ST_OVF;
        end else begin
          done_r <= r_eff;
        end
        rep   <= r_eff;
        first <= 1'b0;
      end
      bsk_pkg::S_SH_RD: begin
        if (idx <= k_idx) begin
          idx <= k_idx;
          cc  <= '0;
        end
      end
      bsk_pkg::S_SH_WR: begin
        if (cc == CC_LAST) begin
          cc  <= '0;
          idx <= idx - 1'b1;
        end else begin
          cc <= cc + 1'b1;
        end
      end
      bsk_pkg::S_BL_K1: knot_a <= k_rdata;
      bsk_pkg::S_BL_P1: prev_p <= p_rdata;
      bsk_pkg::S_BL_MUL: begin
        if (mul_stat.done) begin
          if (cc == CC_LAST) begin
            cc  <= '0;
            idx <= (idx == lo_i) ? KA_W'(kt) : idx - 1'b1;
          end else begin
            cc <= cc + 1'b1;
          end
        end
      end
      bsk_pkg::S_SP_WR:   idx <= idx - 1'b1;
      bsk_pkg::S_SP_LAST: rep <= rep - 1'b1;
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_knot_bound: assert property (@(posedge clk) disable iff (rst)
    int'(kt) <= bsk_pkg::MAX_KNOTS)
    else $error("knot count beyond store depth");

  a_point_bound: assert property (@(posedge clk) disable iff (rst)
    int'(pt) <= bsk_pkg::MAX_POINTS)
    else $error("point count beyond store depth");

  a_curve_kept: assert property (@(posedge clk) disable iff (rst)
    state == bsk_pkg::S_SP_LAST |=> int'(kt) == int'(pt) + int'(degree) + 1)
    else $error("insertion broke knot and point count relation");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy && !mul_stat.busy)
    else $error("divider restarted while busy");

  a_shift_above_span: assert property (@(posedge clk) disable iff (rst)
    state == bsk_pkg::S_SH_WR |-> idx > k_idx)
    else $error("point shift wrote at or below the span");
`endif

endmodule
